>>> rtl/stack_with_running_minimum_defines.svh
// ----------------------------------------------------------------------------
// Stack with running minimum - assertion macros
// Shared assertion shorthands for the stack RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_RUNNING_MINIMUM_DEFINES_SVH
`define STACK_WITH_RUNNING_MINIMUM_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SWRM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition on one edge is followed by a consequence on the next.
`define SWRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// Stack with running minimum - package
// Shared constants, codes and control structs.
// ----------------------------------------------------------------------------
package swrm_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;

   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 7;
   localparam int ERR_W     = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_FIELDS_W = 2 * VALUE_W + COUNT_W + 1 + ERR_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   // controller -> datapath
   typedef struct packed {
      logic    push;      // store the request value on top
      logic    pop;       // drop the top entry
      logic    pop_read;  // fetch the entry below the old top
      logic    load_ram;  // take the fetched entry as the new top
      logic    load_rsp;  // capture the response payload
      err_type err;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic deep;  // two or more entries held
   } stat_type;

endpackage

>>> rtl/swrm_ram.sv
// ----------------------------------------------------------------------------
// Stack with running minimum - generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module swrm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/swrm_ctrl.sv
// ----------------------------------------------------------------------------
// Stack with running minimum - controller
// Request handshake, error decode and response valid.
// ----------------------------------------------------------------------------
`include "stack_with_running_minimum_defines.svh"

module swrm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_kind,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  swrm_pkg::stat_type stat,
   output swrm_pkg::cmd_type  cmd
);

   typedef enum logic {
      IDLE,
      LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      is_pop;
   logic      deep_pop;

   assign req_tready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_pop     = (req_kind == swrm_pkg::REQ_POP);
   assign deep_pop   = accept && is_pop && stat.deep;

   always_comb begin
      cmd          = '0;
      cmd.err      = swrm_pkg::ERR_OK;
      cmd.push     = accept && !is_pop && !stat.full;
      cmd.pop      = accept && is_pop && !stat.empty;
      cmd.pop_read = deep_pop;
      cmd.load_ram = (state_ff == LOAD);
      cmd.load_rsp = (accept && !deep_pop) || (state_ff == LOAD);
      if (accept && !is_pop && stat.full) begin
         cmd.err = swrm_pkg::ERR_FULL;
      end else if (accept && is_pop && stat.empty) begin
         cmd.err = swrm_pkg::ERR_EMPTY;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         IDLE: begin
            if (deep_pop) begin
               state_in = LOAD;
            end else if (accept) begin
               rsp_valid_in = 1'b1;
            end
         end
         LOAD: begin
            state_in     = IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `SWRM_ASSERT(a_load_slot_free, clock, reset, (state_ff == LOAD) |-> !rsp_valid_ff, "response slot busy during refill")
   `SWRM_ASSERT_NEXT(a_deep_pop_loads, clock, reset, deep_pop, (state_ff == LOAD), "deep pop did not refill")
   `SWRM_ASSERT_NEXT(a_accept_responds, clock, reset, accept && !deep_pop, rsp_valid_ff, "request without response")

endmodule

>>> rtl/swrm_dp.sv
// ----------------------------------------------------------------------------
// Stack with running minimum - datapath
// Cached top entry, fill count, entry RAM and response register.
// ----------------------------------------------------------------------------
`include "stack_with_running_minimum_defines.svh"

module swrm_dp #(
   parameter int STACK_DEPTH = swrm_pkg::STACK_DEPTH,
   parameter int DATA_WIDTH  = swrm_pkg::DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swrm_pkg::cmd_type                   cmd,
   input  logic [swrm_pkg::VALUE_W-1:0]        req_value,
   output swrm_pkg::stat_type                  stat,
   output logic [swrm_pkg::RSP_TDATA_W-1:0]    rsp_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int VW = swrm_pkg::VALUE_W;

   logic [CW-1:0]                   count_ff, count_in;
   logic signed [DATA_WIDTH-1:0]    top_ff, top_in;
   logic signed [DATA_WIDTH-1:0]    min_ff, min_in;
   logic [swrm_pkg::RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic [DATA_WIDTH+VW-1:0]        in_wide;
   logic signed [DATA_WIDTH-1:0]    new_val;
   logic signed [DATA_WIDTH-1:0]    new_min;
   logic [CW-1:0]                   count_m1, count_m2;
   logic [2*DATA_WIDTH-1:0]         rd_data;
   logic [DATA_WIDTH+VW-1:0]        top_ext, min_ext;
   logic [CW+swrm_pkg::COUNT_W-1:0] count_wide;
   logic [VW-1:0]                   top_out, min_out;
   logic                            empty_out;

   // cut or zero-extend the request value to the stored width
   assign in_wide  = {{DATA_WIDTH{1'b0}}, req_value};
   assign new_val  = in_wide[DATA_WIDTH-1:0];
   assign new_min  = ((count_ff == '0) || (new_val < min_ff)) ? new_val : min_ff;
   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);

   swrm_ram #(
      .WIDTH (2 * DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.push && (count_ff != '0)),
      .wr_addr (count_m1[AW-1:0]),
      .wr_data ({min_ff, top_ff}),
      .rd_en   (cmd.pop_read),
      .rd_addr (count_m2[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      top_in   = top_ff;
      min_in   = min_ff;
      count_in = count_ff;
      if (cmd.push) begin
         top_in   = new_val;
         min_in   = new_min;
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_m1;
      end else if (cmd.load_ram) begin
         top_in = rd_data[DATA_WIDTH-1:0];
         min_in = rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
      end
   end

   // sign-extend, then keep the low 32 bits; read zero when empty
   assign top_ext    = {{VW{top_in[DATA_WIDTH-1]}}, top_in};
   assign min_ext    = {{VW{min_in[DATA_WIDTH-1]}}, min_in};
   assign empty_out  = (count_in == '0);
   assign top_out    = empty_out ? '0 : top_ext[VW-1:0];
   assign min_out    = empty_out ? '0 : min_ext[VW-1:0];
   assign count_wide = {{swrm_pkg::COUNT_W{1'b0}}, count_in};

   assign rsp_in = {{swrm_pkg::RSP_PAD_W{1'b0}}, cmd.err, empty_out,
                    count_wide[swrm_pkg::COUNT_W-1:0], min_out, top_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      min_ff <= min_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(STACK_DEPTH));
   assign stat.deep  = (count_ff > CW'(1));
   assign rsp_data   = rsp_ff;

   `SWRM_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(STACK_DEPTH), "fill count beyond depth")
   `SWRM_ASSERT_NEXT(a_push_count, clock, reset, cmd.push, count_ff == $past(count_ff) + CW'(1), "push did not advance count")
   `SWRM_ASSERT(a_min_not_above_top, clock, reset, (count_ff != '0) && !cmd.load_ram |-> min_ff <= top_ff, "minimum above top")

endmodule

>>> rtl/stack_with_running_minimum.sv
// ----------------------------------------------------------------------------
// Stack with running minimum - top level
// Bounded LIFO of signed words that also reports the minimum it holds.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): tuser selects push (0) or pop (1), tdata holds
//   the push value. Every request returns exactly one response on rsp_*:
//   new top, new minimum, entry count, empty flag and error code.
//   A push on a full stack or a pop on an empty stack is dropped and flagged
//   in the error code; top and minimum read 0 while the stack is empty.
// Response path and throughput:
//   Push, error and pop-to-empty: response in the cycle after the request.
//   Pop leaving entries: the entry below the top is read through the
//   registered read port of the entry RAM, then the response is registered.
//   Pushes are taken every cycle while responses drain; a pop that refills
//   the top stalls the next request. Top entry in registers, rest in RAM.
// Reset: clears the fill count, response valid and controller state; RAM
//   contents are not cleared and are never read before being written.
// Stall: while a response waits on rsp_tready, a new request is taken only
//   in the cycle the response leaves; otherwise req_tready stays low.
// ----------------------------------------------------------------------------
module stack_with_running_minimum #(
   parameter int STACK_DEPTH = swrm_pkg::STACK_DEPTH,
   parameter int DATA_WIDTH  = swrm_pkg::DATA_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swrm_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [31:0] push_value
   input  logic                               req_tuser,  // [0] req_type
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] top_value, [63:32] min_value, [70:64] entry_count,
   // [71] is_empty, [73:72] error_code, [79:74] zero
   output logic [swrm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   swrm_pkg::cmd_type  cmd;
   swrm_pkg::stat_type stat;

   // handshake, error decode and refill sequencing
   swrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // top registers, fill count, entry RAM and response payload
   swrm_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_tdata),
      .stat      (stat),
      .rsp_data  (rsp_tdata)
   );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack with running minimum - testbench
// Drives push and pop requests from a table of hand-picked cases, then
// random fill, drain and mixed phases. A shadow stack in the bench predicts
// every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

   localparam int VALUE_W     = swrm_pkg::VALUE_W;
   localparam int COUNT_W     = swrm_pkg::COUNT_W;
   localparam int ERR_W       = swrm_pkg::ERR_W;
   localparam int REQ_TDATA_W = swrm_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = swrm_pkg::RSP_TDATA_W;
   localparam int STACK_DEPTH = swrm_pkg::STACK_DEPTH;

   typedef swrm_pkg::req_kind_type req_kind_type;
   typedef swrm_pkg::err_type      err_type;

   localparam req_kind_type REQ_PUSH  = swrm_pkg::REQ_PUSH;
   localparam req_kind_type REQ_POP   = swrm_pkg::REQ_POP;
   localparam err_type      ERR_OK    = swrm_pkg::ERR_OK;
   localparam err_type      ERR_FULL  = swrm_pkg::ERR_FULL;
   localparam err_type      ERR_EMPTY = swrm_pkg::ERR_EMPTY;

   localparam int DIRECTED_N    = 25;
   localparam int RANDOM_ITEMS  = 525;
   localparam int HOLD_CYCLES   = 200;   // one long receiver hold-off
   localparam int STALL_LIMIT   = 1000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 4;     // covers the slowest response path

   localparam logic [VALUE_W-1:0] MAX_WORD = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] MIN_WORD = 32'h8000_0000;

   // One response, unpacked.
   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic signed [VALUE_W-1:0] min_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      is_empty;
      err_type                   error_code;
   } stack_view_type;

   // One row of the directed table. Rows with pinned set carry a response
   // typed in by hand; the others take the shadow stack's prediction.
   typedef struct packed {
      req_kind_type        kind;
      logic [VALUE_W-1:0]  value;
      logic                pinned;
      stack_view_type      view;
   } stimulus_row_type;

   localparam stack_view_type NO_VIEW = '{32'sh0, 32'sh0, 7'd0, 1'b0, ERR_OK};
   localparam stack_view_type EMPTY_OK = '{32'sh0, 32'sh0, 7'd0, 1'b1, ERR_OK};
   localparam stack_view_type EMPTY_ERR = '{32'sh0, 32'sh0, 7'd0, 1'b1, ERR_EMPTY};

   stimulus_row_type directed_rows [DIRECTED_N] = '{
      // pop on an empty stack is flagged and ignored
      '{REQ_POP,  32'h0000_0000, 1'b1, EMPTY_ERR},
      // extremes: the largest value, then the smallest takes the minimum
      '{REQ_PUSH, MAX_WORD,      1'b1, '{MAX_WORD, MAX_WORD, 7'd1, 1'b0, ERR_OK}},
      '{REQ_PUSH, MIN_WORD,      1'b1, '{MIN_WORD, MIN_WORD, 7'd2, 1'b0, ERR_OK}},
      '{REQ_PUSH, 32'h0000_0000, 1'b1, '{32'sh0, MIN_WORD, 7'd3, 1'b0, ERR_OK}},
      '{REQ_PUSH, 32'hFFFF_FFFF, 1'b0, NO_VIEW},
      // pop payload is ignored, so feed it noise
      '{REQ_POP,  32'hFFFF_FFFF, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h1234_5678, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b1, '{MAX_WORD, MAX_WORD, 7'd1, 1'b0, ERR_OK}},
      // pop down to empty, then once more past empty
      '{REQ_POP,  32'h0000_0000, 1'b1, EMPTY_OK},
      '{REQ_POP,  32'hFFFF_FFFF, 1'b1, EMPTY_ERR},
      // equal values do not replace the minimum; smaller ones do
      '{REQ_PUSH, 32'h0000_0005, 1'b1, '{32'sh5, 32'sh5, 7'd1, 1'b0, ERR_OK}},
      '{REQ_PUSH, 32'h0000_0005, 1'b0, NO_VIEW},
      '{REQ_PUSH, 32'h0000_0007, 1'b0, NO_VIEW},
      '{REQ_PUSH, 32'h0000_0003, 1'b0, NO_VIEW},
      '{REQ_PUSH, 32'h0000_0003, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      // negative value and alternating bit patterns
      '{REQ_PUSH, 32'hFFFF_FFF9, 1'b0, NO_VIEW},
      '{REQ_PUSH, 32'h5555_5555, 1'b0, NO_VIEW},
      '{REQ_PUSH, 32'hAAAA_AAAA, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW},
      '{REQ_POP,  32'h0000_0000, 1'b0, NO_VIEW}
   };

   // DUT ports; every input starts at a known value.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [31:0] push_value
   logic                   req_tuser  = 1'b0; // [0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] top_value, [63:32] min_value, [70:64] entry_count,
   // [71] is_empty, [73:72] error_code, [79:74] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow stack and the responses it still owes.
   logic signed [VALUE_W-1:0] shadow_values [STACK_DEPTH];
   logic signed [VALUE_W-1:0] shadow_minima [STACK_DEPTH];
   int                        shadow_fill = 0;
   stack_view_type            expected_views [$];

   int   failures      = 0;
   int   idle_cycles   = 0;
   int   tx_calm       = 0;    // remaining requests sent back to back
   int   rx_calm       = 0;    // remaining receiver cycles with no stall
   int   hold_asks     = 0;    // long receiver hold-offs asked for

   stack_with_running_minimum i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Apply one request to the shadow stack and return the response it owes.
   function automatic stack_view_type step_stack(req_kind_type kind,
                                                 logic signed [VALUE_W-1:0] value);
      stack_view_type view;
      view.error_code = ERR_OK;
      if (kind == REQ_PUSH) begin
         if (shadow_fill >= STACK_DEPTH) begin
            view.error_code = ERR_FULL;
         end else begin
            shadow_values[shadow_fill] = value;
            // keep the old minimum unless the new value is strictly smaller
            if (shadow_fill > 0 && !(value < shadow_minima[shadow_fill - 1]))
               shadow_minima[shadow_fill] = shadow_minima[shadow_fill - 1];
            else
               shadow_minima[shadow_fill] = value;
            shadow_fill++;
         end
      end else if (shadow_fill == 0) begin
         view.error_code = ERR_EMPTY;
      end else begin
         shadow_fill--;
      end
      view.top_value   = (shadow_fill > 0) ? shadow_values[shadow_fill - 1] : '0;
      view.min_value   = (shadow_fill > 0) ? shadow_minima[shadow_fill - 1] : '0;
      view.entry_count = COUNT_W'(shadow_fill);
      view.is_empty    = (shadow_fill == 0);
      return view;
   endfunction

   // Mostly no gap, some short ones, a few long; now and then a calm stretch.
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Full-range words, with extremes and a cluster of small values that
   // makes equal minima likely.
   function automatic logic [VALUE_W-1:0] random_word();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: begin
            case ($urandom_range(0, 3))
               0:       return MAX_WORD;
               1:       return MIN_WORD;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: return VALUE_W'($signed($urandom_range(0, 8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // Offer one request after a random gap, hold it until accepted, then
   // queue the response it owes. tvalid stays high on return.
   task automatic send_request(req_kind_type kind, logic [VALUE_W-1:0] value,
                               logic pinned, stack_view_type pinned_view);
      int             gap;
      stack_view_type predicted;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         // drop valid and scramble the bus while idle
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predicted = step_stack(kind, value);
      expected_views.push_back(pinned ? pinned_view : predicted);
   endtask

   // Drop valid and hold off until every owed response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_views.size() != 0);
   endtask

   task automatic check_field(string name, logic [VALUE_W-1:0] want,
                              logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         failures++;
      end
   endtask

   // Response checker: compare each accepted response with the oldest
   // owed one.
   always @(posedge clock) begin
      stack_view_type want;
      stack_view_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.top_value   = rsp_tdata[VALUE_W-1:0];
         got.min_value   = rsp_tdata[2*VALUE_W-1:VALUE_W];
         got.entry_count = rsp_tdata[2*VALUE_W +: COUNT_W];
         got.is_empty    = rsp_tdata[2*VALUE_W + COUNT_W];
         got.error_code  = err_type'(rsp_tdata[2*VALUE_W + COUNT_W + 1 +: ERR_W]);
         if (expected_views.size() == 0) begin
            $error("response with no request outstanding: tdata 0x%h", rsp_tdata);
            failures++;
         end else begin
            want = expected_views.pop_front();
            check_field("top_value", want.top_value, got.top_value);
            check_field("min_value", want.min_value, got.min_value);
            check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            check_field("error_code", 32'(want.error_code), 32'(got.error_code));
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("stack_with_running_minimum verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request so the
   // response stage backs up and the block stalls its request side.
   initial begin
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_asks) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(rx_calm);
         end
      end
   end

   // Sender and run control.
   initial begin
      int           sent;
      int           phase;
      int           push_pct;
      int           phase_len;
      req_kind_type kind;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      for (int i = 0; i < DIRECTED_N; i++)
         send_request(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].pinned, directed_rows[i].view);
      wait_drained();

      // Random phases. Start with a pure fill well past full and a pure
      // drain well past empty, then run biased or balanced phases at random.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               push_pct  = 100;
               phase_len = STACK_DEPTH + 8;
            end
            1: begin
               push_pct  = 0;
               phase_len = STACK_DEPTH + 8;
            end
            default: begin
               case ($urandom_range(0, 2))
                  0:       push_pct = 85;
                  1:       push_pct = 15;
                  default: push_pct = 50;
               endcase
               phase_len = $urandom_range(20, 90);
            end
         endcase
         // hold the receiver off while requests keep coming
         if (phase == 3) hold_asks++;
         // pause the sender until the block has caught up
         if (phase == 5) wait_drained();
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
            send_request(kind, random_word(), 1'b0, NO_VIEW);
            sent++;
         end
         phase++;
      end

      // Drain, let any late response show up, then report.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("stack_with_running_minimum verification clean");
      else
         $display("stack_with_running_minimum verification failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/swrm_pkg.sv
rtl/swrm_ram.sv
rtl/swrm_ctrl.sv
rtl/swrm_dp.sv
rtl/stack_with_running_minimum.sv
test/testbench.sv
